// ===== hdl/tdfa_pkg.sv =====
// Shared types and constants for the table-driven DFA acceptor.
// No dependencies; imported by the top level and the testbench.
package tdfa_pkg;

	localparam int STATE_COUNT = 16;
	localparam int SYMBOL_BITS = 8;
	localparam int STATE_BITS  = $clog2(STATE_COUNT);
	localparam int STORE_DEPTH = STATE_COUNT << SYMBOL_BITS;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
	localparam int MASK_BITS   = 16;
	localparam int SYM_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FEED  = 2'd1,
		OP_END   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_START_STATE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = CFG_IDX_W'(1);

	typedef struct packed {
		logic                  present;
		logic [STATE_BITS-1:0] next;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ===== hdl/tdfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tdfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/table_driven_dfa_acceptor.sv =====
// Top level of the table-driven DFA acceptor: transition store, word state, verdict.
// Depends on tdfa_pkg and tdfa_ram.
//
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   operation, symbol, from_state, to_state, entry_present
// out      output     out_valid/out_ready accepted, final_state, missing_transition
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle unless stalled by the clearing pass or an end of word. A symbol's
// store read returns the next cycle and feeds the following read address directly, so
// symbols run back to back. The verdict appears in the output register the cycle after
// end of word is taken. After reset a clearing pass over all 4096 entries marks every
// entry absent; input is not taken during it, configuration writes are.
// An end of word also stalls while the output register is full and not taken.
module table_driven_dfa_acceptor
	import tdfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [SYM_W-1:0]      symbol,
	input  logic [STATE_BITS-1:0] from_state,
	input  logic [STATE_BITS-1:0] to_state,
	input  logic                  entry_present,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic [STATE_BITS-1:0] final_state,
	output logic                  missing_transition,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                  clearing_q;
	logic [ADDR_BITS-1:0]  clr_addr_q;
	logic [STATE_BITS-1:0] start_q;
	logic [MASK_BITS-1:0]  mask_q;
	logic [STATE_BITS-1:0] present_q;
	logic                  rejected_q;
	logic                  pend_s1;
	logic                  out_valid_q;
	logic                  accepted_q;
	logic [STATE_BITS-1:0] final_q;
	logic                  missing_q;

	op_t                   op;
	logic                  in_fire;
	logic                  cfg_fire;
	logic [STATE_BITS-1:0] cur_state;
	logic                  cur_rej;
	entry_t                rd_entry;
	entry_t                wr_entry;
	logic                  we;
	logic [ADDR_BITS-1:0]  waddr;
	logic                  re;
	logic [ADDR_BITS-1:0]  raddr;
	logic [ENTRY_BITS-1:0] rdata;

	assign op        = op_t'(operation);
	assign in_ready  = !clearing_q && (op != OP_END || !out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// resolve the read issued last cycle
	assign rd_entry = entry_t'(rdata);
	always_comb begin
		cur_state = present_q;
		cur_rej   = rejected_q;
		if (pend_s1) begin
			if (rd_entry.present) begin
				cur_state = rd_entry.next;
			end else begin
				cur_rej = 1'b1;
			end
		end
	end

	always_comb begin
		wr_entry.present = entry_present;
		wr_entry.next    = to_state;
		we    = clearing_q || (in_fire && op == OP_WRITE);
		waddr = clearing_q ? clr_addr_q : {from_state, symbol[SYMBOL_BITS-1:0]};
		re    = in_fire && op == OP_FEED && !cur_rej;
		raddr = {cur_state, symbol[SYMBOL_BITS-1:0]};
	end

	tdfa_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(clearing_q ? ENTRY_BITS'(0) : ENTRY_BITS'(wr_entry)),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
			if (clr_addr_q == {ADDR_BITS{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			mask_q     <= '0;
			present_q  <= '0;
			rejected_q <= 1'b0;
			pend_s1    <= 1'b0;
		end else begin
			if (cfg_fire && cfg_index == REG_START_STATE) begin
				present_q  <= cfg_data[STATE_BITS-1:0];
				rejected_q <= 1'b0;
				pend_s1    <= 1'b0;
			end else if (in_fire && op == OP_END) begin
				present_q  <= start_q;
				rejected_q <= 1'b0;
				pend_s1    <= re;
			end else begin
				present_q  <= cur_state;
				rejected_q <= cur_rej;
				pend_s1    <= re;
			end
			if (cfg_fire) begin
				case (cfg_index)
					REG_START_STATE: begin
						start_q <= cfg_data[STATE_BITS-1:0];
					end
					REG_ACCEPT_MASK: begin
						mask_q <= cfg_data[MASK_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && op == OP_END) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && op == OP_END) begin
			accepted_q <= !cur_rej && mask_q[cur_state];
			final_q    <= cur_state;
			missing_q  <= cur_rej;
		end
	end

	assign out_valid          = out_valid_q;
	assign accepted           = accepted_q;
	assign final_state        = final_q;
	assign missing_transition = missing_q;

	a_pend_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !rejected_q)
		else $error("store read pending on a rejected word");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && op == OP_END |=> present_q == start_q && !rejected_q && !pend_s1)
		else $error("end of word did not restart at the start state");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_addr_q) == {ADDR_BITS{1'b1}})
		else $error("clearing pass ended early");

	a_no_feed_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !re && !pend_s1)
		else $error("store read during clearing pass");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for table_driven_dfa_acceptor: directed table, then random DFA programs and words.
// Depends on tdfa_pkg; checks each verdict against an in-bench automaton predictor or a pinned expected value.
module tb;
	import tdfa_pkg::*;

	localparam int LIMIT  = 200000;
	localparam int SETTLE = 4;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 210;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

	typedef struct packed {
		logic                  acc;
		logic [STATE_BITS-1:0] fin;
		logic                  miss;
	} verdict_t;

	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [1:0]            op;
		logic [SYM_W-1:0]      sym;
		logic [STATE_BITS-1:0] src;
		logic [STATE_BITS-1:0] dst;
		logic                  pres;
		bit                    pin;
		verdict_t              want;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            operation = OP_NONE;
	logic [SYM_W-1:0]      symbol = '0;
	logic [STATE_BITS-1:0] from_state = '0;
	logic [STATE_BITS-1:0] to_state = '0;
	logic                  entry_present = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  accepted;
	logic [STATE_BITS-1:0] final_state;
	logic                  missing_transition;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit       pin_on = 1'b0;
	verdict_t pin_want = '0;
	bit       calm = 1'b0;

	entry_t                dfa_table [STORE_DEPTH];
	logic [STATE_BITS-1:0] dfa_state;
	logic                  dfa_rejected;
	logic [STATE_BITS-1:0] start_reg;
	logic [MASK_BITS-1:0]  mask_reg;
	verdict_t              verdicts [$];

	int cycles = 0;
	int mismatches = 0;
	int n_writes = 0, n_feeds = 0, n_ends = 0, n_ignored = 0, n_regs = 0;
	int n_verdicts = 0, n_accepts = 0, n_misses = 0;

	step_t plan [$];

	table_driven_dfa_acceptor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.symbol(symbol),
		.from_state(from_state),
		.to_state(to_state),
		.entry_present(entry_present),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.final_state(final_state),
		.missing_transition(missing_transition),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (dfa_table[i]) dfa_table[i] = '0;
		dfa_state    = '0;
		dfa_rejected = 1'b0;
		start_reg    = '0;
		mask_reg     = '0;
	end

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == REG_START_STATE) begin
			start_reg    = val[STATE_BITS-1:0];
			dfa_state    = val[STATE_BITS-1:0];
			dfa_rejected = 1'b0;
		end else if (idx == REG_ACCEPT_MASK) begin
			mask_reg = val[MASK_BITS-1:0];
		end
	endfunction

	function automatic void step_dfa();
		entry_t   e;
		verdict_t v;
		case (operation)
			OP_WRITE: begin
				dfa_table[{from_state, symbol}] = '{present: entry_present, next: to_state};
				n_writes++;
			end
			OP_FEED: begin
				if (!dfa_rejected) begin
					e = dfa_table[{dfa_state, symbol}];
					if (e.present)
						dfa_state = e.next;
					else
						dfa_rejected = 1'b1;
				end
				n_feeds++;
			end
			OP_END: begin
				v.acc  = !dfa_rejected && mask_reg[dfa_state];
				v.fin  = dfa_state;
				v.miss = dfa_rejected;
				verdicts.push_back(pin_on ? pin_want : v);
				dfa_state    = start_reg;
				dfa_rejected = 1'b0;
				n_ends++;
			end
			default: n_ignored++;
		endcase
	endfunction

	function automatic void check_verdict();
		verdict_t want;
		n_verdicts++;
		if (accepted === 1'b1) n_accepts++;
		if (missing_transition === 1'b1) n_misses++;
		if (verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("verdict %0d: none expected, got acc=%0b final=%0d miss=%0b",
					n_verdicts, accepted, final_state, missing_transition);
		end else begin
			want = verdicts.pop_front();
			if (accepted !== want.acc || final_state !== want.fin ||
					missing_transition !== want.miss) begin
				mismatches++;
				if (mismatches <= 10)
					$display("verdict %0d: expected acc=%0b final=%0d miss=%0b, got acc=%0b final=%0d miss=%0b",
						n_verdicts, want.acc, want.fin, want.miss,
						accepted, final_state, missing_transition);
			end
		end
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				n_regs++;
			end
			if (in_valid && in_ready) step_dfa();
			if (out_valid && out_ready) check_verdict();
		end
		out_ready <= calm || ($urandom_range(99) >= 25);
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdicts.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
			input logic [STATE_BITS-1:0] src, input logic [STATE_BITS-1:0] dst,
			input logic pres, input bit pin, input verdict_t want);
		if (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		symbol        <= sym;
		from_state    <= src;
		to_state      <= dst;
		entry_present <= pres;
		pin_on        <= pin;
		pin_want      <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic step_t op_step(logic [1:0] op, logic [SYM_W-1:0] sym,
			logic [STATE_BITS-1:0] src, logic [STATE_BITS-1:0] dst, logic pres);
		step_t s;
		s.is_reg  = 1'b0;
		s.reg_idx = REG_START_STATE;
		s.reg_val = '0;
		s.op      = op;
		s.sym     = sym;
		s.src     = src;
		s.dst     = dst;
		s.pres    = pres;
		s.pin     = 1'b0;
		s.want    = '0;
		return s;
	endfunction

	function automatic step_t end_step(logic acc, logic [STATE_BITS-1:0] fin, logic miss);
		step_t s;
		s      = op_step(OP_END, '0, '0, '0, 1'b0);
		s.pin  = 1'b1;
		s.want = '{acc: acc, fin: fin, miss: miss};
		return s;
	endfunction

	function automatic step_t reg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		step_t s;
		s         = op_step(OP_NONE, '0, '0, '0, 1'b0);
		s.is_reg  = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	initial begin
		logic [SYM_W-1:0] alpha [4];
		logic [STATE_BITS-1:0] st;
		logic [MASK_BITS-1:0] mk;
		int sent, len, r;

		// empty store, start 0, mask 0
		plan.push_back(end_step(1'b0, 4'd0, 1'b0));
		plan.push_back(op_step(OP_FEED, 8'h00, 4'h0, 4'h0, 1'b0));
		plan.push_back(op_step(OP_FEED, 8'hFF, 4'hF, 4'hF, 1'b1));
		plan.push_back(end_step(1'b0, 4'd0, 1'b1));
		plan.push_back(reg_step(REG_START_STATE, 16'hFFFF));
		plan.push_back(reg_step(REG_ACCEPT_MASK, 16'hFFFF));
		plan.push_back(end_step(1'b1, 4'd15, 1'b0));
		plan.push_back(op_step(OP_WRITE, 8'hFF, 4'hF, 4'h0, 1'b1));
		plan.push_back(op_step(OP_WRITE, 8'h00, 4'h0, 4'hF, 1'b1));
		plan.push_back(op_step(OP_FEED, 8'hFF, 4'h0, 4'h0, 1'b0));
		plan.push_back(op_step(OP_FEED, 8'h00, 4'h0, 4'h0, 1'b0));
		plan.push_back(end_step(1'b1, 4'd15, 1'b0));
		plan.push_back(op_step(OP_WRITE, 8'hFF, 4'hF, 4'h0, 1'b0));
		plan.push_back(op_step(OP_FEED, 8'hFF, 4'h0, 4'h0, 1'b0));
		plan.push_back(end_step(1'b0, 4'd15, 1'b1));
		plan.push_back(op_step(OP_NONE, 8'hFF, 4'hF, 4'hF, 1'b1));
		plan.push_back(reg_step(REG_ACCEPT_MASK, 16'h0000));
		plan.push_back(op_step(OP_WRITE, 8'h55, 4'hF, 4'hA, 1'b1));
		plan.push_back(op_step(OP_FEED, 8'h55, 4'h0, 4'h0, 1'b0));
		plan.push_back(op_step(OP_END, 8'h00, 4'h0, 4'h0, 1'b0));
		plan.push_back(reg_step(REG_ACCEPT_MASK, 16'h0400));
		plan.push_back(reg_step(REG_START_STATE, 16'h0000));
		plan.push_back(op_step(OP_FEED, 8'h00, 4'h0, 4'h0, 1'b0));
		// entry added in the middle of a word
		plan.push_back(op_step(OP_WRITE, 8'hAA, 4'hF, 4'hA, 1'b1));
		plan.push_back(op_step(OP_FEED, 8'hAA, 4'h0, 4'h0, 1'b0));
		plan.push_back(reg_step(REG_UNUSED_2, 16'hFFFF));
		plan.push_back(reg_step(REG_UNUSED_3, 16'hA5A5));
		plan.push_back(end_step(1'b1, 4'd10, 1'b0));
		plan.push_back(op_step(OP_FEED, 8'h00, 4'h0, 4'h0, 1'b0));
		// start write restarts the word in progress
		plan.push_back(reg_step(REG_START_STATE, 16'h0003));
		plan.push_back(end_step(1'b0, 4'd3, 1'b0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				push_item(plan[i].op, plan[i].sym, plan[i].src, plan[i].dst, plan[i].pres,
					plan[i].pin, plan[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			calm = (ph == 3);
			case (ph)
				0: begin st = '0; mk = 16'hFFFF; end
				1: begin st = 4'hF; mk = 16'h0000; end
				default: begin st = STATE_BITS'($urandom); mk = MASK_BITS'($urandom); end
			endcase
			write_reg(REG_START_STATE, {12'($urandom), st});
			write_reg(REG_ACCEPT_MASK, mk);

			alpha[0] = ph[0] ? 8'hFF : 8'h00;
			for (int k = 1; k < 4; k++) alpha[k] = SYM_W'($urandom);

			// program a dense automaton over a small alphabet
			sent = 0;
			for (int s = 0; s < STATE_COUNT; s++) begin
				for (int k = 0; k < 4; k++) begin
					push_item(OP_WRITE, alpha[k], STATE_BITS'(s), STATE_BITS'($urandom),
						$urandom_range(99) < 90, 1'b0, '0);
					sent++;
				end
			end

			while (sent < PHASE_ITEMS) begin
				len = $urandom_range(0, 10);
				for (int j = 0; j < len; j++) begin
					r = $urandom_range(99);
					if (r < 4) begin
						push_item(OP_NONE, SYM_W'($urandom), STATE_BITS'($urandom),
							STATE_BITS'($urandom), 1'($urandom), 1'b0, '0);
					end else if (r < 9) begin
						push_item(OP_WRITE, alpha[$urandom_range(3)], STATE_BITS'($urandom),
							STATE_BITS'($urandom), $urandom_range(99) < 75, 1'b0, '0);
						sent++;
					end else if (r < 17) begin
						push_item(OP_FEED, SYM_W'($urandom), STATE_BITS'($urandom),
							STATE_BITS'($urandom), 1'($urandom), 1'b0, '0);
						sent++;
					end else begin
						push_item(OP_FEED, alpha[$urandom_range(3)], STATE_BITS'($urandom),
							STATE_BITS'($urandom), 1'($urandom), 1'b0, '0);
						sent++;
					end
				end
				push_item(OP_END, SYM_W'($urandom), STATE_BITS'($urandom),
					STATE_BITS'($urandom), 1'($urandom), 1'b0, '0);
				sent++;
			end
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);

		$display("Drove %0d entry writes, %0d symbols, %0d word ends, %0d ignored ops, %0d config writes.",
			n_writes, n_feeds, n_ends, n_ignored, n_regs);
		$display("Checked %0d verdicts (%0d accepted, %0d with a missing transition), %0d mismatches.",
			n_verdicts, n_accepts, n_misses, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== table_driven_dfa_acceptor.f =====
hdl/tdfa_pkg.sv
hdl/tdfa_ram.sv
hdl/table_driven_dfa_acceptor.sv
verif/tb.sv
